>>> design/tcw_pkg.sv
package tcw_pkg;

   // fixed field widths of the request, response and csr words
   localparam int REQ_TYPE_W   = 2;
   localparam int CHAR_W       = 16;
   localparam int ATTR_W       = 32;
   localparam int READ_ROW_W   = 6;
   localparam int READ_COL_W   = 7;
   localparam int CURSOR_COL_W = 7;
   localparam int CURSOR_ROW_W = 6;
   localparam int TAB_W        = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;
   // wide enough to hold any buffer dimension itself
   localparam int DIM_W        = 9;

   // request types
   localparam logic [REQ_TYPE_W-1:0] REQ_PUT        = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR_ALL  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR_LINE = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ       = 2'd3;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_SIZE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_ATTR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_ATTR = 2'd3;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 16'h0020;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_MIN = 16'd32;
   localparam logic [CHAR_W-1:0] CHAR_LF        = 16'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR        = 16'd13;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 16'd9;

   localparam logic [TAB_W-1:0] TAB_SIZE_RESET = 8'd8;

   // classified command handed from the front end to the back end
   typedef enum logic [2:0] {
      OP_NOP,
      OP_PRINT,
      OP_LF,
      OP_CR,
      OP_TAB,
      OP_CLEAR_ALL,
      OP_CLEAR_LINE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [CHAR_W-1:0]       char_code;
      logic                    is_wide;
      logic [READ_ROW_W-1:0]   row;
      logic [READ_COL_W-1:0]   col;
   } cmd_type;

   typedef struct packed {
      logic                tab_mode;
      logic [TAB_W-1:0]    tab_size;
      logic [ATTR_W-1:0]   default_attribute;
      logic [ATTR_W-1:0]   current_attribute;
   } cfg_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   char_code;
      logic [ATTR_W-1:0]   attr;
      logic                cont;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   // back end status seen by the front end
   typedef struct packed {
      logic pop;
      logic init;
   } back_stat_type;

endpackage

>>> design/tcw_req_if.sv
interface tcw_req_if;
   import tcw_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [CHAR_W-1:0]       char_code;
   logic                    is_wide;
   logic [READ_ROW_W-1:0]   read_row;
   logic [READ_COL_W-1:0]   read_col;

   modport source (
      output valid, req_type, char_code, is_wide, read_row, read_col,
      input  ready
   );

   modport sink (
      input  valid, req_type, char_code, is_wide, read_row, read_col,
      output ready
   );

endinterface

>>> design/tcw_rsp_if.sv
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CURSOR_COL_W-1:0]   cursor_col;
   logic [CURSOR_ROW_W-1:0]   cursor_row;
   logic [CHAR_W-1:0]         cell_char;
   logic [ATTR_W-1:0]         cell_attr;
   logic                      cell_cont;

   modport source (
      output valid, cursor_col, cursor_row, cell_char, cell_attr, cell_cont,
      input  ready
   );

   modport sink (
      input  valid, cursor_col, cursor_row, cell_char, cell_attr, cell_cont,
      output ready
   );

endinterface

>>> design/tcw_csr_if.sv
interface tcw_csr_if;
   import tcw_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_W-1:0]    index;
   logic [CSR_DATA_W-1:0]   data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );

endinterface

>>> design/tcw_ram.sv
module tcw_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 8192
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tcw_front.sv
module tcw_front #(
   parameter int BUFFER_WIDTH  = 128,
   parameter int BUFFER_HEIGHT = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   tcw_req_if.sink                 req_chan,
   input  tcw_pkg::back_stat_type  back_stat,
   output logic                    cmd_valid,
   output tcw_pkg::cmd_type        cmd
);
   import tcw_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   cmd_type               entry_in;
   cmd_type               queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  push;
   logic                  row_ok;
   logic                  col_ok;

   // classify the request word
   always_comb begin
      entry_in.char_code = req_chan.char_code;
      entry_in.is_wide   = req_chan.is_wide;
      entry_in.row       = req_chan.read_row;
      entry_in.col       = req_chan.read_col;
      row_ok = DIM_W'(req_chan.read_row) < DIM_W'(BUFFER_HEIGHT);
      col_ok = DIM_W'(req_chan.read_col) < DIM_W'(BUFFER_WIDTH);
      case (req_chan.req_type)
         REQ_PUT: begin
            if (req_chan.char_code < CHAR_PRINT_MIN) begin
               if (req_chan.char_code == CHAR_LF) begin
                  entry_in.op = OP_LF;
               end else if (req_chan.char_code == CHAR_CR) begin
                  entry_in.op = OP_CR;
               end else if (req_chan.char_code == CHAR_TAB) begin
                  entry_in.op = OP_TAB;
               end else begin
                  entry_in.op = OP_NOP;
               end
            end else begin
               entry_in.op = OP_PRINT;
            end
         end
         REQ_CLEAR_ALL:  entry_in.op = OP_CLEAR_ALL;
         REQ_CLEAR_LINE: entry_in.op = OP_CLEAR_LINE;
         REQ_READ:       entry_in.op = (row_ok && col_ok) ? OP_READ : OP_NOP;
         default:        entry_in.op = OP_NOP;
      endcase
   end

   // command queue toward the back end
   assign req_chan.ready = (count_ff != CNT_W'(QUEUE_DEPTH)) && !back_stat.init;
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = count_ff != '0;
   assign cmd            = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = back_stat.pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !back_stat.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && back_stat.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

>>> design/tcw_back.sv
module tcw_back #(
   parameter int BUFFER_WIDTH  = 128,
   parameter int BUFFER_HEIGHT = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  tcw_pkg::cmd_type        cmd,
   input  tcw_pkg::cfg_type        cfg,
   output tcw_pkg::back_stat_type  back_stat,
   tcw_rsp_if.source               rsp_chan
);
   import tcw_pkg::*;

   localparam int XW     = $clog2(BUFFER_WIDTH);
   localparam int YW     = $clog2(BUFFER_HEIGHT);
   localparam int AW     = XW + YW;
   localparam int DEPTH  = BUFFER_HEIGHT * (2 ** XW);
   localparam int DIV_CW = $clog2(XW + 1);
   localparam logic [XW-1:0] X_LAST   = XW'(BUFFER_WIDTH - 1);
   localparam logic [YW-1:0] Y_LAST   = YW'(BUFFER_HEIGHT - 1);
   localparam logic [YW:0]   HEIGHT_V = (YW + 1)'(BUFFER_HEIGHT);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_SWEEP = 3'd3;
   localparam logic [2:0] S_PUT   = 3'd4;
   localparam logic [2:0] S_TDIV  = 3'd5;
   localparam logic [2:0] S_TAB   = 3'd6;

   function automatic logic [YW-1:0] phys_row(input logic [YW-1:0] base,
                                               input logic [YW-1:0] r);
      logic [YW:0] sum;
      sum = {1'b0, base} + {1'b0, r};
      if (sum >= HEIGHT_V) begin
         sum = sum - HEIGHT_V;
      end
      return sum[YW-1:0];
   endfunction

   logic [2:0]                state_ff, state_in;
   logic [XW-1:0]             cur_x_ff, cur_x_in;
   logic [YW-1:0]             cur_y_ff, cur_y_in;
   logic [YW-1:0]             top_ff, top_in;
   logic [YW-1:0]             row_ff, row_in;
   logic [XW-1:0]             col_ff, col_in;
   logic                      all_ff, all_in;
   logic                      resume_ff, resume_in;
   logic                      second_ff, second_in;
   logic                      first_ff, first_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [TAB_W-1:0]          rem_ff, rem_in;
   logic [XW-1:0]             div_x_ff, div_x_in;
   logic [DIV_CW-1:0]         div_cnt_ff, div_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_COL_W-1:0]   cursor_col_ff, cursor_col_in;
   logic [CURSOR_ROW_W-1:0]   cursor_row_ff, cursor_row_in;
   cell_type                  cell_ff, cell_in;

   logic                      slot_free;
   logic                      pop;
   logic                      finish;
   cell_type                  cell_val;
   logic [TAB_W-1:0]          tab_step;
   logic                      x_wrap;
   logic [XW-1:0]             x_next;
   logic                      y_bottom;
   logic [YW-1:0]             top_next;
   logic [YW-1:0]             cur_prow;
   logic [TAB_W:0]            phase_inc;
   logic [TAB_W-1:0]          phase_next;
   logic [TAB_W:0]            div_sh;
   logic [TAB_W:0]            div_sub;
   logic [TAB_W-1:0]          div_res;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   cell_type                  ram_wdata;
   logic                      ram_re;
   logic [AW-1:0]             ram_raddr;
   logic [CELL_W-1:0]         ram_rdata;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // cursor stepping helpers
   always_comb begin
      tab_step   = (cfg.tab_size == '0) ? TAB_W'(1) : cfg.tab_size;
      x_wrap     = cur_x_ff == X_LAST;
      x_next     = x_wrap ? '0 : cur_x_ff + XW'(1);
      y_bottom   = cur_y_ff == Y_LAST;
      top_next   = (top_ff == Y_LAST) ? '0 : top_ff + YW'(1);
      cur_prow   = phys_row(top_ff, cur_y_ff);
      phase_inc  = {1'b0, rem_ff} + (TAB_W + 1)'(1);
      if (x_wrap || phase_inc == {1'b0, tab_step}) begin
         phase_next = '0;
      end else begin
         phase_next = phase_inc[TAB_W-1:0];
      end
      // one remainder bit per cycle, column msb first
      div_sh  = {rem_ff, div_x_ff[XW-1]};
      div_sub = div_sh - {1'b0, tab_step};
      div_res = (div_sh >= {1'b0, tab_step}) ? div_sub[TAB_W-1:0] : div_sh[TAB_W-1:0];
   end

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop       = (state_ff == S_IDLE) && cmd_valid && slot_free;

   always_comb begin
      state_in   = state_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      top_in     = top_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      all_in     = all_ff;
      resume_in  = resume_ff;
      second_in  = second_ff;
      first_in   = first_ff;
      cmd_in     = cmd_ff;
      rem_in     = rem_ff;
      div_x_in   = div_x_ff;
      div_cnt_in = div_cnt_ff;
      finish     = 1'b0;
      cell_val   = '0;

      ram_we              = 1'b0;
      ram_waddr           = {cur_prow, cur_x_ff};
      ram_wdata.char_code = cmd_ff.char_code;
      ram_wdata.attr      = cfg.current_attribute;
      ram_wdata.cont      = 1'b0;
      ram_re              = 1'b0;
      ram_raddr           = {phys_row(top_ff, YW'(cmd.row)), XW'(cmd.col)};

      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               cmd_in = cmd;
               case (cmd.op)
                  OP_READ: begin
                     ram_re   = 1'b1;
                     state_in = S_READ;
                  end
                  OP_CR: begin
                     cur_x_in = '0;
                     finish   = 1'b1;
                  end
                  OP_LF: begin
                     if (y_bottom) begin
                        // scroll: old top row becomes the new bottom row
                        top_in    = top_next;
                        row_in    = top_ff;
                        col_in    = '0;
                        all_in    = 1'b0;
                        resume_in = 1'b0;
                        state_in  = S_SWEEP;
                     end else begin
                        cur_y_in = cur_y_ff + YW'(1);
                        finish   = 1'b1;
                     end
                  end
                  OP_CLEAR_ALL: begin
                     row_in    = '0;
                     col_in    = '0;
                     all_in    = 1'b1;
                     resume_in = 1'b0;
                     state_in  = S_SWEEP;
                  end
                  OP_CLEAR_LINE: begin
                     row_in    = cur_prow;
                     col_in    = '0;
                     all_in    = 1'b0;
                     resume_in = 1'b0;
                     state_in  = S_SWEEP;
                  end
                  OP_PRINT: begin
                     second_in = 1'b0;
                     state_in  = S_PUT;
                  end
                  OP_TAB: begin
                     rem_in     = '0;
                     div_x_in   = cur_x_ff;
                     div_cnt_in = DIV_CW'(XW);
                     state_in   = S_TDIV;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            cell_val = cell_type'(ram_rdata);
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         S_INIT, S_SWEEP: begin
            ram_we              = 1'b1;
            ram_waddr           = {row_ff, col_ff};
            ram_wdata.char_code = CHAR_SPACE;
            ram_wdata.attr      = (state_ff == S_INIT) ? '0 : cfg.default_attribute;
            ram_wdata.cont      = 1'b0;
            if (col_ff == X_LAST) begin
               col_in = '0;
               if (all_ff && row_ff != Y_LAST) begin
                  row_in = row_ff + YW'(1);
               end else if (state_ff == S_INIT) begin
                  state_in = S_IDLE;
               end else if (resume_ff) begin
                  second_in = 1'b1;
                  state_in  = S_PUT;
               end else begin
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               col_in = col_ff + XW'(1);
            end
         end
         S_PUT: begin
            ram_we         = 1'b1;
            ram_wdata.cont = second_ff;
            cur_x_in       = x_next;
            if (x_wrap && y_bottom) begin
               top_in    = top_next;
               row_in    = top_ff;
               col_in    = '0;
               all_in    = 1'b0;
               resume_in = cmd_ff.is_wide && !second_ff;
               state_in  = S_SWEEP;
            end else begin
               if (x_wrap) begin
                  cur_y_in = cur_y_ff + YW'(1);
               end
               if (cmd_ff.is_wide && !second_ff) begin
                  second_in = 1'b1;
               end else begin
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_TDIV: begin
            rem_in     = div_res;
            div_x_in   = div_x_ff << 1;
            div_cnt_in = div_cnt_ff - DIV_CW'(1);
            if (div_cnt_ff == DIV_CW'(1)) begin
               first_in = 1'b1;
               state_in = S_TAB;
            end
         end
         S_TAB: begin
            ram_we         = cfg.tab_mode;
            ram_wdata.cont = !first_ff;
            cur_x_in       = x_next;
            first_in       = 1'b0;
            rem_in         = phase_next;
            if (x_wrap && y_bottom) begin
               top_in    = top_next;
               row_in    = top_ff;
               col_in    = '0;
               all_in    = 1'b0;
               resume_in = 1'b0;
               state_in  = S_SWEEP;
            end else begin
               if (x_wrap) begin
                  cur_y_in = cur_y_ff + YW'(1);
               end
               if (phase_next == '0) begin
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      cell_in       = cell_ff;
      if (finish) begin
         rsp_valid_in  = 1'b1;
         cursor_col_in = CURSOR_COL_W'(cur_x_in);
         cursor_row_in = CURSOR_ROW_W'(cur_y_in);
         cell_in       = cell_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         top_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         all_ff       <= 1'b1;
         resume_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         top_ff       <= top_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         all_ff       <= all_in;
         resume_ff    <= resume_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      second_ff     <= second_in;
      first_ff      <= first_in;
      cmd_ff        <= cmd_in;
      rem_ff        <= rem_in;
      div_x_ff      <= div_x_in;
      div_cnt_ff    <= div_cnt_in;
      cursor_col_ff <= cursor_col_in;
      cursor_row_ff <= cursor_row_in;
      cell_ff       <= cell_in;
   end

   assign back_stat.pop  = pop;
   assign back_stat.init = state_ff == S_INIT;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_col = cursor_col_ff;
   assign rsp_chan.cursor_row = cursor_row_ff;
   assign rsp_chan.cell_char  = cell_ff.char_code;
   assign rsp_chan.cell_attr  = cell_ff.attr;
   assign rsp_chan.cell_cont  = cell_ff.cont;

endmodule

>>> design/text_console_char_writer_core.sv
// text console cell buffer with a cursor. each request word (put char, clear buffer,
// clear cursor line, read cell) gives exactly one response word carrying the cursor
// after the request and, for an in-range read, the cell contents (zero otherwise).
// rows form a ring in one cell memory with a single write port, so all work that
// touches cells goes one cell per cycle: a printable char writes one cell (two when wide),
// cr, ignored codes and out-of-range reads write none, an in-range read reads one, a tab
// first finds the cursor column modulo the tab size and then steps one column at a time,
// clear line blanks the cursor row and clear buffer blanks every row; a scroll also clears
// the new bottom row. after reset a clearing pass over every cell runs during which no
// request is taken (csr writes are). a two-word queue sits between the request decoder
// and the cell engine, and the response register lets the decoder keep taking requests
// while a response waits.
module text_console_char_writer_core #(
   parameter int BUFFER_WIDTH  = 128,
   parameter int BUFFER_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req_chan,
   tcw_rsp_if.source   rsp_chan,
   tcw_csr_if.sink     csr_chan
);
   import tcw_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            cmd_valid;
   cmd_type         cmd;
   back_stat_type   back_stat;

   // csr registers, always writable
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_TAB_MODE:     cfg_in.tab_mode          = csr_chan.data[0];
            CSR_TAB_SIZE:     cfg_in.tab_size          = csr_chan.data[TAB_W-1:0];
            CSR_DEFAULT_ATTR: cfg_in.default_attribute = csr_chan.data[ATTR_W-1:0];
            CSR_CURRENT_ATTR: cfg_in.current_attribute = csr_chan.data[ATTR_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tab_mode          <= 1'b0;
         cfg_ff.tab_size          <= TAB_SIZE_RESET;
         cfg_ff.default_attribute <= '0;
         cfg_ff.current_attribute <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: decode and classify request words into the command queue
   tcw_front #(
      .BUFFER_WIDTH  (BUFFER_WIDTH),
      .BUFFER_HEIGHT (BUFFER_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .back_stat (back_stat),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   // back: cursor, ring position, cell memory and the response register
   tcw_back #(
      .BUFFER_WIDTH  (BUFFER_WIDTH),
      .BUFFER_HEIGHT (BUFFER_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .back_stat (back_stat),
      .rsp_chan  (rsp_chan)
   );

   // cursor reported in a response is always inside the buffer
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> DIM_W'(rsp_chan.cursor_col) < DIM_W'(BUFFER_WIDTH))
      else $error("cursor column outside buffer");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> DIM_W'(rsp_chan.cursor_row) < DIM_W'(BUFFER_HEIGHT))
      else $error("cursor row outside buffer");

   // no request taken and no response shown during the clearing pass
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      back_stat.init |-> !req_chan.ready && !rsp_chan.valid)
      else $error("activity during clearing pass");

   // the cell engine only takes a command the queue holds
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      back_stat.pop |-> cmd_valid)
      else $error("command queue popped while empty");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tcw_pkg::*;

   // buffer geometry, kept equal to the dut parameters below
   localparam int BUF_W = 128;
   localparam int BUF_H = 64;
   localparam int CELLS = BUF_W * BUF_H;

   // extra settle time after the last response, sized from the buffer geometry
   localparam int SETTLE_CYCLES = CELLS + 2 * BUF_W;
   // the longest legal quiet stretches are a full clear pass and the settle wait, so allow several of them
   localparam int STALL_LIMIT = 4 * CELLS;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_WORDS = 140;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]   kind;
      logic [CHAR_W-1:0]       code;
      logic                    wide;
      logic [READ_ROW_W-1:0]   row;
      logic [READ_COL_W-1:0]   col;
   } req_word_type;

   typedef struct packed {
      logic [CURSOR_COL_W-1:0] col;
      logic [CURSOR_ROW_W-1:0] row;
      logic [CHAR_W-1:0]       ch;
      logic [ATTR_W-1:0]       attr;
      logic                    cont;
   } rsp_word_type;

   logic clock;
   logic reset;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();
   tcw_csr_if csr_bus ();

   text_console_char_writer_core #(
      .BUFFER_WIDTH  (BUF_W),
      .BUFFER_HEIGHT (BUF_H)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // shadow copy of the console: cell store, cursor, ring position, registers
   logic [CHAR_W-1:0] shadow_char [CELLS];
   logic [ATTR_W-1:0] shadow_attr [CELLS];
   logic              shadow_cont [CELLS];
   int unsigned       cur_x;
   int unsigned       cur_y;
   int unsigned       top_line;
   cfg_type           console_cfg;

   // responses still owed by the dut, oldest first
   rsp_word_type pending_rsp [$];
   rsp_word_type want;

   int   mismatches;
   int   rsp_seen;
   int   quiet_cycles;
   int   hold_request;
   logic no_idle;

   // clock: 20 ns period
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // console prediction
   // ---------------------------------------------------------------------------------

   // logical row to physical row in the ring
   function automatic int unsigned phys_line(input int unsigned logical);
      return (top_line + logical) % BUF_H;
   endfunction

   // blank one physical row with the default attribute
   function automatic void blank_line(input int unsigned prow);
      int unsigned x;
      for (x = 0; x < BUF_W; x++) begin
         shadow_char[prow * BUF_W + x] = CHAR_SPACE;
         shadow_attr[prow * BUF_W + x] = console_cfg.default_attribute;
         shadow_cont[prow * BUF_W + x] = 1'b0;
      end
   endfunction

   // cursor down one row; at the bottom the ring scrolls and the new last row is blanked
   function automatic void advance_row();
      if (cur_y + 1 >= BUF_H) begin
         top_line = (top_line + 1) % BUF_H;
         blank_line(phys_line(BUF_H - 1));
         cur_y = BUF_H - 1;
      end else begin
         cur_y++;
      end
   endfunction

   // cursor right one column, wrapping onto the next row
   function automatic void advance_col();
      cur_x++;
      if (cur_x >= BUF_W) begin
         cur_x = 0;
         advance_row();
      end
   endfunction

   // write one cell at the cursor with the current attribute and step on
   function automatic void write_cell(input logic [CHAR_W-1:0] code, input logic cont);
      int unsigned idx;
      idx = phys_line(cur_y) * BUF_W + cur_x;
      shadow_char[idx] = code;
      shadow_attr[idx] = console_cfg.current_attribute;
      shadow_cont[idx] = cont;
      advance_col();
   endfunction

   // apply one request word to the shadow console and return the response word it gives
   function automatic rsp_word_type console_response(input req_word_type w);
      rsp_word_type r;
      int unsigned  tab_stop;
      int unsigned  y;
      int unsigned  idx;
      r = '0;
      // tab size zero behaves as one
      tab_stop = (console_cfg.tab_size == 0) ? 1 : console_cfg.tab_size;
      case (w.kind)
         REQ_PUT: begin
            if (w.code < CHAR_PRINT_MIN) begin
               // control codes, wide flag ignored
               if (w.code == CHAR_LF) begin
                  advance_row();
               end else if (w.code == CHAR_CR) begin
                  cur_x = 0;
               end else if (w.code == CHAR_TAB) begin
                  if (console_cfg.tab_mode) begin
                     // tab cells up to the stop, all after the first are continuations
                     write_cell(w.code, 1'b0);
                     while (cur_x % tab_stop != 0) write_cell(w.code, 1'b1);
                  end else begin
                     advance_col();
                     while (cur_x % tab_stop != 0) advance_col();
                  end
               end
            end else begin
               write_cell(w.code, 1'b0);
               // continuation cell may land on the next row, possibly scrolling
               if (w.wide) write_cell(w.code, 1'b1);
            end
         end
         REQ_CLEAR_ALL: begin
            for (y = 0; y < BUF_H; y++) blank_line(y);
         end
         REQ_CLEAR_LINE: begin
            blank_line(phys_line(cur_y));
         end
         REQ_READ: begin
            // out of range reads give zero cell fields
            if (w.row < BUF_H && w.col < BUF_W) begin
               idx = phys_line(w.row) * BUF_W + w.col;
               r.ch = shadow_char[idx];
               r.attr = shadow_attr[idx];
               r.cont = shadow_cont[idx];
            end
         end
         default: ;
      endcase
      r.col = cur_x[CURSOR_COL_W-1:0];
      r.row = cur_y[CURSOR_ROW_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------

   // idle gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int unsigned pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic req_word_type make_req(input logic [REQ_TYPE_W-1:0] kind,
                                             input logic [CHAR_W-1:0] code,
                                             input logic wide,
                                             input int unsigned row,
                                             input int unsigned col);
      req_word_type w;
      w.kind = kind;
      w.code = code;
      w.wide = wide;
      w.row = row[READ_ROW_W-1:0];
      w.col = col[READ_COL_W-1:0];
      return w;
   endfunction

   // random request word: mostly text and line control, reads near the cursor
   function automatic req_word_type random_request();
      req_word_type w;
      int unsigned  pick;
      w.kind = REQ_PUT;
      w.code = CHAR_W'($urandom);
      w.wide = 1'($urandom);
      w.row = READ_ROW_W'($urandom);
      w.col = READ_COL_W'($urandom);
      pick = $urandom_range(0, 999);
      if (pick < 450) begin
         // printable, some wide, sometimes the code extremes
         w.wide = ($urandom_range(0, 9) < 3);
         case ($urandom_range(0, 9))
            0: w.code = CHAR_PRINT_MIN;
            1: w.code = '1;
            default: w.code = CHAR_W'($urandom_range(CHAR_PRINT_MIN, 16'hFFFF));
         endcase
      end else if (pick < 600) begin
         w.code = CHAR_LF;
      end else if (pick < 650) begin
         w.code = CHAR_CR;
      end else if (pick < 730) begin
         w.code = CHAR_TAB;
      end else if (pick < 760) begin
         // any control code, the ignored ones included
         w.code = CHAR_W'($urandom_range(0, CHAR_PRINT_MIN - 1));
      end else if (pick < 960) begin
         w.kind = REQ_READ;
         // most reads look at what was just written
         if ($urandom_range(0, 9) < 7) begin
            w.row = READ_ROW_W'(cur_y + BUF_H - $urandom_range(0, 2));
            w.col = READ_COL_W'(cur_x + BUF_W - $urandom_range(0, 4));
         end
      end else if (pick < 995) begin
         w.kind = REQ_CLEAR_LINE;
      end else begin
         w.kind = REQ_CLEAR_ALL;
      end
      return w;
   endfunction

   // offer one request word, optionally after an idle gap, and log its response
   task automatic send_req(input req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= w.kind;
      req_bus.char_code <= w.code;
      req_bus.is_wide   <= w.wide;
      req_bus.read_row  <= w.row;
      req_bus.read_col  <= w.col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_rsp.push_back(console_response(w));
   endtask

   // one csr word; valid stays up so several writes go back to back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_TAB_MODE:     console_cfg.tab_mode = data[0];
         CSR_TAB_SIZE:     console_cfg.tab_size = data[TAB_W-1:0];
         CSR_DEFAULT_ATTR: console_cfg.default_attribute = data;
         CSR_CURRENT_ATTR: console_cfg.current_attribute = data;
         default: ;
      endcase
   endtask

   // stop offering, wait for every owed response, then wait out the settle time
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // reprogram all four registers with the dut idle
   task automatic set_config(input logic mode, input logic [TAB_W-1:0] size,
                             input logic [ATTR_W-1:0] dflt, input logic [ATTR_W-1:0] attr);
      wait_idle();
      write_reg(CSR_TAB_MODE, {{(CSR_DATA_W-1){1'b0}}, mode});
      write_reg(CSR_TAB_SIZE, {{(CSR_DATA_W-TAB_W){1'b0}}, size});
      write_reg(CSR_DEFAULT_ATTR, dflt);
      write_reg(CSR_CURRENT_ATTR, attr);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at response %0d: %s", rsp_seen, what);
   endtask

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------

   // cells straight after the clearing pass, at both corners
   task automatic test_reset_state();
      send_req(make_req(REQ_READ, '0, 1'b0, 0, 0));
      send_req(make_req(REQ_READ, '1, 1'b1, BUF_H - 1, BUF_W - 1));
   endtask

   // printable extremes, every control code class, clears; reset register values
   task automatic test_control_codes();
      send_req(make_req(REQ_PUT, 16'h0041, 1'b0, 0, 0));
      send_req(make_req(REQ_PUT, 16'hFFFF, 1'b1, 0, 0));
      // ignored control codes, wide flag set
      send_req(make_req(REQ_PUT, 16'h0000, 1'b1, 0, 0));
      send_req(make_req(REQ_PUT, CHAR_PRINT_MIN - CHAR_W'(1), 1'b1, 0, 0));
      // tab moves to the next stop at reset tab size
      send_req(make_req(REQ_PUT, CHAR_TAB, 1'b0, 0, 0));
      send_req(make_req(REQ_PUT, CHAR_PRINT_MIN, 1'b0, 0, 0));
      send_req(make_req(REQ_PUT, CHAR_CR, 1'b1, 0, 0));
      send_req(make_req(REQ_PUT, CHAR_LF, 1'b0, 0, 0));
      send_req(make_req(REQ_PUT, 16'h007E, 1'b0, 0, 0));
      send_req(make_req(REQ_READ, '0, 1'b0, 0, 0));
      send_req(make_req(REQ_READ, '0, 1'b0, 0, 1));
      send_req(make_req(REQ_READ, '0, 1'b0, 0, 2));
      // clear the cursor line, then check it
      send_req(make_req(REQ_CLEAR_LINE, '1, 1'b1, BUF_H - 1, BUF_W - 1));
      send_req(make_req(REQ_READ, '0, 1'b0, 1, 0));
      send_req(make_req(REQ_CLEAR_ALL, '0, 1'b0, 0, 0));
      send_req(make_req(REQ_READ, '0, 1'b0, 0, 1));
   endtask

   // tab cells up to the last column, then a wide char split over two rows
   task automatic test_wrap_and_tabs();
      set_config(1'b1, TAB_W'(BUF_W - 1), '1, 32'hA5A5_5A5A);
      send_req(make_req(REQ_PUT, CHAR_CR, 1'b0, 0, 0));
      send_req(make_req(REQ_PUT, CHAR_TAB, 1'b1, 0, 0));
      send_req(make_req(REQ_PUT, 16'h4E2D, 1'b1, 0, 0));
      send_req(make_req(REQ_READ, '0, 1'b0, cur_y - 1, BUF_W - 2));
      send_req(make_req(REQ_READ, '0, 1'b0, cur_y - 1, BUF_W - 1));
      send_req(make_req(REQ_READ, '0, 1'b0, cur_y, 0));
      send_req(make_req(REQ_CLEAR_LINE, '0, 1'b0, 0, 0));
   endtask

   // random traffic under a series of register settings, extremes first
   task automatic test_random_phases();
      int phase;
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_config(1'b1, 8'd8, '0, '1);
            1: set_config(1'b0, 8'd1, '1, '0);
            2: set_config(1'b1, 8'd0, $urandom, $urandom);
            3: set_config(1'b0, TAB_W'(BUF_W), $urandom, $urandom);
            4: set_config(1'b1, 8'd255, $urandom, $urandom);
            5: set_config(1'b0, TAB_W'(BUF_W - 1), $urandom, $urandom);
            default: set_config(1'($urandom), TAB_W'($urandom_range(2, 16)),
                                $urandom, $urandom);
         endcase
         // one phase runs with no idling on either side
         no_idle = (phase == 6);
         repeat (PHASE_WORDS) send_req(random_request());
      end
      no_idle = 1'b0;
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      no_idle = 1'b1;
      hold_request = HOLD_CYCLES;
      repeat (40) send_req(random_request());
      no_idle = 1'b0;
   endtask

   task automatic finish_run();
      wait_idle();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   endtask

   // ---------------------------------------------------------------------------------
   // processes
   // ---------------------------------------------------------------------------------

   // main sequence
   initial begin
      int unsigned y;
      mismatches = 0;
      rsp_seen = 0;
      hold_request = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= REQ_PUT;
      req_bus.char_code <= '0;
      req_bus.is_wide   <= 1'b0;
      req_bus.read_row  <= '0;
      req_bus.read_col  <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_TAB_MODE;
      csr_bus.data  <= '0;
      // shadow console in its reset state
      console_cfg.tab_mode = 1'b0;
      console_cfg.tab_size = TAB_SIZE_RESET;
      console_cfg.default_attribute = '0;
      console_cfg.current_attribute = '0;
      cur_x = 0;
      cur_y = 0;
      top_line = 0;
      for (y = 0; y < BUF_H; y++) blank_line(y);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // first words wait out the clearing pass through the handshake
      test_reset_state();
      test_control_codes();
      test_wrap_and_tabs();
      test_random_phases();
      test_backpressure();
      finish_run();
   end

   // receiver pacing: random ready runs and stalls, plus the long hold when asked
   initial begin : rsp_pacing
      int   run_left;
      logic run_ready;
      run_left = 0;
      run_ready = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            run_ready = 1'b0;
            run_left = hold_request;
            hold_request = 0;
         end else if (run_left <= 0) begin
            if (no_idle || $urandom_range(0, 2) != 0) begin
               run_ready = 1'b1;
               run_left = $urandom_range(1, 16);
            end else begin
               run_ready = 1'b0;
               run_left = 1 + pick_gap();
            end
         end
         rsp_bus.ready <= run_ready;
         run_left--;
      end
   end

   // response check against the oldest owed word
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("response word with none expected");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.cursor_col !== want.col)
               report_mismatch($sformatf("cursor_col got %0d, expected %0d",
                                         rsp_bus.cursor_col, want.col));
            if (rsp_bus.cursor_row !== want.row)
               report_mismatch($sformatf("cursor_row got %0d, expected %0d",
                                         rsp_bus.cursor_row, want.row));
            if (rsp_bus.cell_char !== want.ch)
               report_mismatch($sformatf("cell_char got %h, expected %h",
                                         rsp_bus.cell_char, want.ch));
            if (rsp_bus.cell_attr !== want.attr)
               report_mismatch($sformatf("cell_attr got %h, expected %h",
                                         rsp_bus.cell_attr, want.attr));
            if (rsp_bus.cell_cont !== want.cont)
               report_mismatch($sformatf("cell_cont got %b, expected %b",
                                         rsp_bus.cell_cont, want.cont));
         end
      end
   end

   // watchdog: too long with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

endmodule
